// ===== sv/sbprt_pkg.sv =====
// ----------------------------------------------------------------------------
// sbprt_pkg
// shared constants and types of the spectral bin peak/rms tracker
// ----------------------------------------------------------------------------
`default_nettype none

package sbprt_pkg;

  localparam int BINS     = 32;
  localparam int BIN_W    = $clog2(BINS);
  localparam int IDX_W    = 5;
  localparam int VAL_W    = 24;
  localparam int RAD_W    = 2 * VAL_W;
  localparam int SQ_STEPS = VAL_W;
  localparam int CNT_W    = $clog2(SQ_STEPS);

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0] level;
    logic [VAL_W-1:0] all_time;
    logic [VAL_W-1:0] peak;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic sq1;
    logic sq2;
    logic sum;
    logic root;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_update;
    logic in_range;
    logic root_last;
    logic out_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/sbprt_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbprt_ctrl
// item sequencer: load, square, sum and bit-serial root (updates only), write back
// ----------------------------------------------------------------------------
`default_nettype none

module sbprt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sbprt_pkg::dp_sts_t sts,
  output sbprt_pkg::dp_cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SQ2,
    S_SUM,
    S_ROOT,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (sts.is_update && sts.in_range) begin
          state_nxt = S_SQ2;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SQ2:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_ROOT;
      S_ROOT: begin
        if (sts.root_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready    = (state_r == S_IDLE);
  assign cmd.capture = (state_r == S_IDLE) && in_valid;
  assign cmd.sq1     = (state_r == S_LOAD) && sts.is_update && sts.in_range;
  assign cmd.sq2     = (state_r == S_SQ2);
  assign cmd.sum     = (state_r == S_SUM);
  assign cmd.root    = (state_r == S_ROOT);
  assign cmd.finish  = (state_r == S_DONE) && !sts.out_busy;

endmodule

`default_nettype wire

// ===== sv/sbprt_dp.sv =====
// ----------------------------------------------------------------------------
// sbprt_dp
// bin store, squaring multiplier, bit-serial square root and result register
// ----------------------------------------------------------------------------
`default_nettype none

module sbprt_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_kind,
  input  wire logic [sbprt_pkg::IDX_W-1:0]       in_bin,
  input  wire logic [sbprt_pkg::VAL_W-1:0]       in_mag,
  input  wire logic                              in_clr,
  input  wire sbprt_pkg::dp_cmd_t                cmd,
  output sbprt_pkg::dp_sts_t                     sts,
  output logic [sbprt_pkg::VAL_W-1:0]            out_peak,
  output logic [sbprt_pkg::VAL_W-1:0]            out_all_time,
  output logic [sbprt_pkg::VAL_W-1:0]            out_level,
  output logic                                   out_changed,
  output logic                                   out_new_max,
  output logic                                   out_valid,
  input  wire logic                              out_ready
);

  logic                            kind_r;
  logic [sbprt_pkg::IDX_W-1:0]     bin_r;
  logic [sbprt_pkg::VAL_W-1:0]     mag_r;
  logic                            clr_r;

  sbprt_pkg::entry_t               mem_r [sbprt_pkg::BINS];
  logic [sbprt_pkg::BINS-1:0]      vld_r;
  sbprt_pkg::entry_t               rd_r;
  logic                            rd_vld_r;
  sbprt_pkg::entry_t               cur;

  logic [sbprt_pkg::BIN_W-1:0]     cap_idx;
  logic [sbprt_pkg::BIN_W-1:0]     idx;
  logic                            in_range;

  logic [sbprt_pkg::VAL_W-1:0]     mul_a;
  logic [sbprt_pkg::RAD_W-1:0]     mul_p;
  logic [sbprt_pkg::RAD_W-1:0]     prod_r;
  logic [sbprt_pkg::RAD_W:0]       sum_r;
  logic [sbprt_pkg::RAD_W:0]       tot;
  logic [sbprt_pkg::RAD_W-1:0]     rad_r;
  logic [sbprt_pkg::VAL_W:0]       rem_r;
  logic [sbprt_pkg::VAL_W-1:0]     root_r;
  logic [sbprt_pkg::CNT_W-1:0]     cnt_r;
  logic [sbprt_pkg::VAL_W+2:0]     rem_t;
  logic [sbprt_pkg::VAL_W+2:0]     trial;
  logic [sbprt_pkg::VAL_W+2:0]     diff;
  logic                            ge;

  logic                            chg_r;
  logic                            maxf_r;
  logic                            chg_nxt;
  logic                            maxf_nxt;
  logic                            wr_en;
  sbprt_pkg::entry_t               wr_ent;
  sbprt_pkg::entry_t               res_nxt;
  logic                            peak_up;
  logic                            max_up;

  sbprt_pkg::entry_t               res_r;
  logic                            out_chg_r;
  logic                            out_maxf_r;
  logic                            out_valid_r;

  assign cap_idx  = sbprt_pkg::BIN_W'(in_bin);
  assign idx      = sbprt_pkg::BIN_W'(bin_r);
  assign in_range = (int'(bin_r) < sbprt_pkg::BINS);
  assign cur      = rd_vld_r ? rd_r : '0;

  // item capture and store read
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r   <= in_kind;
      bin_r    <= in_bin;
      mag_r    <= in_mag;
      clr_r    <= in_clr;
      rd_r     <= mem_r[cap_idx];
      rd_vld_r <= vld_r[cap_idx];
    end
  end

  // store write
  always_ff @(posedge clk) begin
    if (cmd.finish && wr_en) begin
      mem_r[idx] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.finish && wr_en) begin
      vld_r[idx] <= 1'b1;
    end
  end

  // shared squaring multiplier
  assign mul_a = cmd.sq1 ? cur.level : mag_r;
  assign mul_p = mul_a * mul_a;
  assign tot   = sum_r + {1'b0, prod_r};

  // one root bit per step
  assign rem_t = {rem_r, rad_r[sbprt_pkg::RAD_W-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign ge    = (rem_t >= trial);
  assign diff  = rem_t - trial;

  always_ff @(posedge clk) begin
    if (cmd.sq1) begin
      prod_r <= mul_p;
    end
    if (cmd.sq2) begin
      sum_r  <= {1'b0, prod_r};
      prod_r <= mul_p;
    end
    if (cmd.sum) begin
      rad_r  <= tot[sbprt_pkg::RAD_W:1];
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end
    if (cmd.root) begin
      rem_r  <= ge ? diff[sbprt_pkg::VAL_W:0] : rem_t[sbprt_pkg::VAL_W:0];
      root_r <= {root_r[sbprt_pkg::VAL_W-2:0], ge};
      rad_r  <= rad_r << 2;
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  // result and write-back entry
  always_comb begin
    res_nxt  = '0;
    wr_en    = 1'b0;
    wr_ent   = cur;
    chg_nxt  = chg_r;
    maxf_nxt = maxf_r;
    peak_up  = (mag_r > cur.peak);
    max_up   = (mag_r >= cur.all_time);
    if (in_range) begin
      if (kind_r == sbprt_pkg::KIND_UPDATE) begin
        wr_en           = 1'b1;
        wr_ent.peak     = peak_up ? mag_r : cur.peak;
        wr_ent.all_time = max_up ? mag_r : cur.all_time;
        wr_ent.level    = root_r;
        chg_nxt         = chg_r | peak_up;
        maxf_nxt        = maxf_r | max_up;
        res_nxt         = wr_ent;
      end else begin
        res_nxt = cur;
        if (bin_r == '0) begin
          chg_nxt  = 1'b0;
          maxf_nxt = 1'b0;
        end
        if (clr_r) begin
          wr_en        = 1'b1;
          wr_ent.peak  = '0;
          wr_ent.level = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_r      <= res_nxt;
      out_chg_r  <= chg_nxt;
      out_maxf_r <= maxf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chg_r       <= 1'b0;
      maxf_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        chg_r       <= chg_nxt;
        maxf_r      <= maxf_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.is_update = (kind_r == sbprt_pkg::KIND_UPDATE);
  assign sts.in_range  = in_range;
  assign sts.root_last = (cnt_r == sbprt_pkg::CNT_W'(sbprt_pkg::SQ_STEPS - 1));
  assign sts.out_busy  = out_valid_r && !out_ready;

  assign out_peak     = res_r.peak;
  assign out_all_time = res_r.all_time;
  assign out_level    = res_r.level;
  assign out_changed  = out_chg_r;
  assign out_new_max  = out_maxf_r;
  assign out_valid    = out_valid_r;

`ifndef ASSERT_OFF
  a_update_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && in_range && kind_r == sbprt_pkg::KIND_UPDATE) |=>
      (res_r.peak >= $past(mag_r) && res_r.all_time >= $past(mag_r) &&
       res_r.peak <= res_r.all_time))
    else $error("update result below magnitude or peak above all-time peak");

  a_rms_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && in_range && kind_r == sbprt_pkg::KIND_UPDATE) |->
      (root_r <= cur.level || root_r <= mag_r))
    else $error("rms level above both inputs");

  a_bin0_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && kind_r == sbprt_pkg::KIND_READ && bin_r == '0) |=>
      (!out_chg_r && !out_maxf_r && !chg_r && !maxf_r))
    else $error("readout of bin zero left a sticky flag set");
`endif

endmodule

`default_nettype wire

// ===== sv/spectral_bin_peak_rms_tracker_core.sv =====
// ----------------------------------------------------------------------------
// spectral_bin_peak_rms_tracker_core
// per-bin peak hold, all-time peak and running rms level tracker
// ----------------------------------------------------------------------------
// items are taken one at a time: in_tready is high only in the idle state
// updates load, square, sum, run the 24-step bit-serial square root and write
// back; readouts load and finish, and both wait while the output is full
// a finished item may wait in the output register while the next is taken
// reset: synchronous rst_n clears per-bin valid bits and both sticky flags,
// so every bin reads as zero at once with no clearing pass
`default_nettype none

module spectral_bin_peak_rms_tracker_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // bin_index, magnitude, clear_after_read
  input  wire logic        in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata   // peak_value, all_time_peak, level_value,
                                       // peak_changed, new_maximum
);

  sbprt_pkg::dp_cmd_t              cmd;
  sbprt_pkg::dp_sts_t              sts;
  logic [sbprt_pkg::VAL_W-1:0]     peak_value;
  logic [sbprt_pkg::VAL_W-1:0]     all_time_peak;
  logic [sbprt_pkg::VAL_W-1:0]     level_value;
  logic                            peak_changed;
  logic                            new_maximum;

  sbprt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbprt_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_kind      (in_tuser),
    .in_bin       (in_tdata[4:0]),
    .in_mag       (in_tdata[28:5]),
    .in_clr       (in_tdata[29]),
    .cmd          (cmd),
    .sts          (sts),
    .out_peak     (peak_value),
    .out_all_time (all_time_peak),
    .out_level    (level_value),
    .out_changed  (peak_changed),
    .out_new_max  (new_maximum),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready)
  );

  assign out_tdata = {6'b0, new_maximum, peak_changed, level_value, all_time_peak,
                      peak_value};

endmodule

`default_nettype wire
